[rtl/urd_pkg.sv]
// Package for the radix digit emitter.
// Holds field widths, register indexes, reset values and the symbol lookup.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package urd_pkg;

	localparam int RADIX_W   = 5;
	localparam int DIGIT_W   = 4;
	localparam int SYM_W     = 8;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HI = 2'd2;

	localparam logic [RADIX_W-1:0] RADIX_RESET      = 5'd10;
	localparam logic [CFG_W-1:0]   SYMBOLS_LO_RESET = 64'h3736353433323130;
	localparam logic [CFG_W-1:0]   SYMBOLS_HI_RESET = 64'h6665646362613938;

	function automatic logic [SYM_W-1:0] sym_lookup(
		input logic [CFG_W-1:0]   lo,
		input logic [CFG_W-1:0]   hi,
		input logic [DIGIT_W-1:0] d
	);
		logic [CFG_W-1:0] word;
		word = d[3] ? hi : lo;
		return word[{d[2:0], 3'b000} +: SYM_W];
	endfunction

endpackage

`default_nettype wire

[rtl/urd_if.sv]
// Stream interfaces for the radix digit emitter: number input and symbol output.
// Depends on urd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface urd_in_if #(
	parameter int VALUE_WIDTH = 64
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface urd_out_if;
	import urd_pkg::*;

	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             last;

	modport source (output valid, output symbol, output last, input ready);
	modport sink (input valid, input symbol, input last, output ready);
endinterface

`default_nettype wire

[rtl/unsigned_to_radix_digits_core.sv]
// Top level of the radix digit emitter: configuration registers and sequencer.
// Depends on urd_pkg, urd_if, urd_divider and urd_digit_stack.
//
//   channel   direction  payload              transfer when
//   item      in         value                item.valid && item.ready
//   digit     out        symbol, last         digit.valid && digit.ready
//   cfg       in         cfg_index, cfg_wdata cfg_we
//
// Each digit is produced by the bit-serial divider and written to the digit
// store, then the digits are read back in reverse order through the S_RD and
// S_EMIT steps, so the last digit divided out is the first symbol emitted.
// Reset returns the registers to radix 10 and the symbols "0123456789abcdef".
// The input is not ready until the final symbol of an item has entered the
// output register; a stalled output holds the sequencer in its emit step.
`timescale 1ns / 1ps
`default_nettype none

module unsigned_to_radix_digits_core #(
	parameter int VALUE_WIDTH = 64,
	parameter int MAX_RADIX   = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [urd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [urd_pkg::CFG_W-1:0]       cfg_wdata,
	urd_in_if.sink                               item,
	urd_out_if.source                            digit
);
	import urd_pkg::*;

	localparam int RADIX_TOP = (MAX_RADIX > 16) ? 16 : ((MAX_RADIX < 2) ? 2 : MAX_RADIX);
	localparam int IDX_W     = $clog2(VALUE_WIDTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_RD,
		S_EMIT
	} state_t;

	state_t               state_q;
	logic [RADIX_W-1:0]   radix_q;
	logic [CFG_W-1:0]     symbols_lo_q;
	logic [CFG_W-1:0]     symbols_hi_q;
	logic [RADIX_W-1:0]   eff_radix_q;
	logic [RADIX_W-1:0]   eff_radix;
	logic [IDX_W-1:0]     wr_ptr_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 out_valid_q;
	logic [SYM_W-1:0]     symbol_q;
	logic                 last_q;

	logic                   accept;
	logic                   div_start;
	logic [VALUE_WIDTH-1:0] div_dividend;
	logic                   div_done;
	logic [VALUE_WIDTH-1:0] div_quotient;
	logic [DIGIT_W-1:0]     div_remainder;
	logic [DIGIT_W-1:0]     rd_digit;
	logic                   more;
	logic                   out_free;
	logic                   emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q      <= RADIX_RESET;
			symbols_lo_q <= SYMBOLS_LO_RESET;
			symbols_hi_q <= SYMBOLS_HI_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RADIX:      radix_q      <= cfg_wdata[RADIX_W-1:0];
				REG_SYMBOLS_LO: symbols_lo_q <= cfg_wdata;
				REG_SYMBOLS_HI: symbols_hi_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (radix_q < RADIX_W'(2)) begin
			eff_radix = RADIX_W'(2);
		end else if (radix_q > RADIX_W'(RADIX_TOP)) begin
			eff_radix = RADIX_W'(RADIX_TOP);
		end else begin
			eff_radix = radix_q;
		end
	end

	assign accept       = item.valid && (state_q == S_IDLE);
	assign more         = (div_quotient != '0);
	assign div_start    = accept || ((state_q == S_DIV) && div_done && more);
	assign div_dividend = accept ? item.value : div_quotient;
	assign out_free     = !out_valid_q || digit.ready;
	assign emit         = (state_q == S_EMIT) && out_free;

	urd_divider #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (accept ? eff_radix : eff_radix_q),
		.done      (div_done),
		.quotient  (div_quotient),
		.remainder (div_remainder)
	);

	urd_digit_stack #(
		.DEPTH (VALUE_WIDTH)
	) u_stack (
		.clk     (clk),
		.wr_en   ((state_q == S_DIV) && div_done),
		.wr_addr (wr_ptr_q),
		.wr_data (div_remainder),
		.rd_addr (idx_q),
		.rd_data (rd_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			eff_radix_q <= RADIX_W'(2);
			wr_ptr_q    <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			symbol_q    <= '0;
			last_q      <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (digit.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						eff_radix_q <= eff_radix;
						wr_ptr_q    <= '0;
						state_q     <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						idx_q    <= wr_ptr_q;
						wr_ptr_q <= wr_ptr_q + 1'b1;
						if (!more) begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						symbol_q    <= sym_lookup(symbols_lo_q, symbols_hi_q, rd_digit);
						last_q      <= (idx_q == '0);
						if (idx_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q - 1'b1;
							state_q <= S_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign item.ready   = (state_q == S_IDLE);
	assign digit.valid  = out_valid_q;
	assign digit.symbol = symbol_q;
	assign digit.last   = last_q;

endmodule

`default_nettype wire

[rtl/urd_divider.sv]
// Bit-serial restoring divider: one quotient bit per cycle, divisor up to 16.
// Depends on urd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module urd_divider #(
	parameter int VALUE_WIDTH = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [VALUE_WIDTH-1:0]       dividend,
	input  wire logic [urd_pkg::RADIX_W-1:0]  divisor,
	output logic                              done,
	output logic [VALUE_WIDTH-1:0]            quotient,
	output logic [urd_pkg::DIGIT_W-1:0]       remainder
);
	import urd_pkg::*;

	localparam int BIT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

	logic                   busy_q;
	logic                   done_q;
	logic [BIT_W-1:0]       bit_q;
	logic [VALUE_WIDTH-1:0] acc_q;
	logic [DIGIT_W-1:0]     rem_q;
	logic [RADIX_W-1:0]     part;
	logic [RADIX_W-1:0]     diff;
	logic                   ge;

	assign part = {rem_q, acc_q[VALUE_WIDTH-1]};
	assign ge   = (part >= divisor);
	assign diff = part - divisor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				bit_q  <= BIT_W'(VALUE_WIDTH - 1);
			end else if (busy_q) begin
				if (bit_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					bit_q <= bit_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			acc_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[VALUE_WIDTH-2:0], ge};
			rem_q <= ge ? diff[DIGIT_W-1:0] : part[DIGIT_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = acc_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

[rtl/urd_digit_stack.sv]
// Digit store: one write port and one registered read port.
// Depends on urd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module urd_digit_stack #(
	parameter int DEPTH = 64
) (
	input  wire logic                               clk,
	input  wire logic                               wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]           wr_addr,
	input  wire logic [urd_pkg::DIGIT_W-1:0]        wr_data,
	input  wire logic [$clog2(DEPTH)-1:0]           rd_addr,
	output logic [urd_pkg::DIGIT_W-1:0]             rd_data
);
	import urd_pkg::*;

	logic [DIGIT_W-1:0] mem [DEPTH];
	logic [DIGIT_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire
